### hw/rtl/dks_pkg.sv
// dks_pkg: shared types, permutation tables and helper functions for the
// des key schedule cell chain. No dependencies.
`timescale 1ns / 1ps

package dks_pkg;

	localparam int unsigned KEY_W    = 64;
	localparam int unsigned HALF_W   = 28;
	localparam int unsigned CD_W     = 56;
	localparam int unsigned SUBKEY_W = 48;
	localparam int unsigned ROUNDS   = 16;
	localparam int unsigned ROUND_W  = 4;
	localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd15;

	// the two key halves after the initial key permutation
	typedef struct packed {
		logic [HALF_W-1:0] c;
		logic [HALF_W-1:0] d;
	} cd_t;

	// what one cell hands to its neighbor
	typedef struct packed {
		logic               valid;
		logic [ROUND_W-1:0] rnd;
		cd_t                cd;
	} cell_beat_t;

	// bit positions numbered from 1 at the msb
	localparam logic [6:0] PC1_TAB [56] = '{
		7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
		7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
		7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
		7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
		7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
		7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
		7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
		7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
	};

	localparam logic [5:0] PC2_TAB [48] = '{
		6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
		6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
		6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
		6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
		6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
		6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
	};

	// one means a single-bit rotate, zero a double rotate
	localparam logic [ROUNDS-1:0] ROT_ONE = 16'b1000_0001_0000_0011;

	// initial key permutation, split into halves
	function automatic cd_t pc1(input logic [KEY_W-1:0] k);
		logic [CD_W-1:0] acc;
		for (int i = 0; i < 56; i++) begin
			acc[55-i] = k[KEY_W - int'(PC1_TAB[i])];
		end
		return cd_t'(acc);
	endfunction

	// subkey compression permutation on the joined halves
	function automatic logic [SUBKEY_W-1:0] pc2(input cd_t cd);
		logic [CD_W-1:0]     j;
		logic [SUBKEY_W-1:0] acc;
		j = cd;
		for (int i = 0; i < 48; i++) begin
			acc[47-i] = j[CD_W - int'(PC2_TAB[i])];
		end
		return acc;
	endfunction

endpackage

### hw/rtl/dks_cell.sv
// dks_cell: one round of the key schedule chain, rotates both halves and
// registers them for the next cell. Depends on dks_pkg.
`timescale 1ns / 1ps

module dks_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rot_one,
	input  logic [3:0]          rnd,
	input  dks_pkg::cell_beat_t beat_in,
	output dks_pkg::cell_beat_t beat_out
);
	import dks_pkg::*;

	cd_t  rot_cd;
	logic valid_q;
	logic [ROUND_W-1:0] rnd_q;
	cd_t  cd_q;

	// left rotate of both halves by one or two
	always_comb begin
		if (rot_one) begin
			rot_cd.c = {beat_in.cd.c[HALF_W-2:0], beat_in.cd.c[HALF_W-1]};
			rot_cd.d = {beat_in.cd.d[HALF_W-2:0], beat_in.cd.d[HALF_W-1]};
		end else begin
			rot_cd.c = {beat_in.cd.c[HALF_W-3:0], beat_in.cd.c[HALF_W-1 -: 2]};
			rot_cd.d = {beat_in.cd.d[HALF_W-3:0], beat_in.cd.d[HALF_W-1 -: 2]};
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= beat_in.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		cd_q  <= rot_cd;
		rnd_q <= rnd;
	end

	assign beat_out.valid = valid_q;
	assign beat_out.rnd   = rnd_q;
	assign beat_out.cd    = cd_q;

endmodule

### hw/rtl/dks_out_stage.sv
// dks_out_stage: picks the one live cell of the chain, applies the subkey
// compression permutation and registers the result beat. Depends on dks_pkg.
`timescale 1ns / 1ps

module dks_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dks_pkg::cell_beat_t           cells [16],
	output logic                          strobe,
	output logic [dks_pkg::SUBKEY_W-1:0]  subkey,
	output logic [dks_pkg::ROUND_W-1:0]   round,
	output logic                          last
);
	import dks_pkg::*;

	cell_beat_t sel;
	logic strobe_q;
	logic [SUBKEY_W-1:0] subkey_q;
	logic [ROUND_W-1:0]  round_q;
	logic last_q;

	// at most one cell is live, so an and-or select suffices
	always_comb begin
		sel = '0;
		for (int i = 0; i < ROUNDS; i++) begin
			sel = sel | (cells[i] & {$bits(cell_beat_t){cells[i].valid}});
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= sel.valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		subkey_q <= pc2(sel.cd);
		round_q  <= sel.rnd;
		last_q   <= (sel.rnd == LAST_ROUND);
	end

	assign strobe = strobe_q;
	assign subkey = subkey_q;
	assign round  = round_q;
	assign last   = last_q;

endmodule

### hw/rtl/des_key_schedule_top.sv
// des_key_schedule_top: des key schedule built as a chain of sixteen round
// cells plus a registered output stage. Depends on dks_pkg, dks_cell and
// dks_out_stage.
`timescale 1ns / 1ps

// usage
// - input: drive key and raise start; the key is taken at a rising edge with
//   start high and busy low.
// - output: sixteen result beats, one per cycle, in round order; each beat is
//   on subkey, round and last for exactly one cycle with strobe high. last
//   marks round 15. the receiver cannot stall and must take every beat.
// - path: the round 0 beat is registered in the first cell and again in the
//   output stage before it reaches the ports; later rounds follow in order.
// - new keys: busy is high while the key walks through the first fifteen
//   cells, set by the single result channel that carries one subkey a cycle.
//   a new key may enter at the edge where the previous key leaves its last
//   cell, so beats run back to back without a gap.
// - reset: arst_n clears all valid bits and the strobe; nothing else needs
//   clearing and the block is ready right after reset.
module des_key_schedule_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [dks_pkg::KEY_W-1:0]     key,
	output logic                          strobe,
	output logic [dks_pkg::SUBKEY_W-1:0]  subkey,
	output logic [dks_pkg::ROUND_W-1:0]   round,
	output logic                          last
);
	import dks_pkg::*;

	cell_beat_t chain_in  [ROUNDS];
	cell_beat_t chain_out [ROUNDS];
	logic [ROUNDS-1:0] live;
	logic accept;

	assign accept = start && !busy;

	// first cell takes the key after the initial key permutation
	always_comb begin
		chain_in[0].valid = accept;
		chain_in[0].rnd   = '0;
		chain_in[0].cd    = pc1(key);
	end

	// the row of round cells
	for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign chain_in[i] = chain_out[i-1];
		end
		dks_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.rot_one  (ROT_ONE[i]),
			.rnd      (ROUND_W'(i)),
			.beat_in  (chain_in[i]),
			.beat_out (chain_out[i])
		);
		assign live[i] = chain_out[i].valid;
	end

	// busy until the key has reached the last cell
	assign busy = |live[ROUNDS-2:0];

	dks_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.cells  (chain_out),
		.strobe (strobe),
		.subkey (subkey),
		.round  (round),
		.last   (last)
	);

	// only one key may be in the chain at a time
	a_one_live: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(live))
		else $error("more than one cell live");

	// an accepted key lands in the first cell
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> live[0])
		else $error("accepted key missing from first cell");

	// beats of one key come back to back with rising round
	a_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && (round == ROUND_W'($past(round) + 4'd1)))
		else $error("result beats out of order");

endmodule
